FILE: rtl/core/papp_pkg.sv
// Shared constants and types for the probe advertisement payload parser.
// No dependencies; used by papp_pair_ram and probe_advert_payload_parser_core.
package papp_pkg;

    localparam int MAX_PAYLOAD_DEF = 18;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 5;
    localparam int LEN_W      = 6;
    localparam int TENTHS_W   = 16;
    localparam int SLOT_W     = 3;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = 3;

    localparam logic [CNT_W-1:0] CNT_SAT = 5'd31;

    // packet types
    localparam logic [3:0] PT_NAME   = 4'd0;
    localparam logic [3:0] PT_TEMP   = 4'd1;
    localparam logic [3:0] PT_STATUS = 4'd3;

    // temperature layouts
    localparam logic [1:0] LAY_V3     = 2'd0;
    localparam logic [1:0] LAY_V2     = 2'd1;
    localparam logic [1:0] LAY_LEGACY = 2'd2;

    localparam logic [3:0] OFF_V3_BASE  = 4'd2;
    localparam logic [3:0] OFF_V2_BASE  = 4'd4;
    localparam logic [3:0] OFF_LEG_AMB  = 4'd12;
    localparam logic [3:0] OFF_LEG_FOOD = 4'd10;

    localparam logic [3:0]       VER_MAJ_V2     = 4'd2;
    localparam logic [3:0]       VER_MAJ_V3     = 4'd3;
    localparam logic [LEN_W-1:0] MIN_LEN        = 6'd2;
    localparam logic [LEN_W-1:0] MIN_TEMP_LEN   = 6'd14;
    localparam logic [LEN_W-1:0] MIN_STATUS_LEN = 6'd10;

    // configuration register indexes
    localparam logic REG_MIN_TENTHS = 1'b0;
    localparam logic REG_MAX_TENTHS = 1'b1;

    localparam logic signed [TENTHS_W-1:0] MIN_TENTHS_RST = -16'sd400;
    localparam logic signed [TENTHS_W-1:0] MAX_TENTHS_RST = 16'sd6000;

    typedef struct packed {
        logic              status;
        logic [3:0]        ptype;
        logic [3:0]        maj;
        logic [3:0]        mnr;
        logic [3:0]        pat;
        logic              hb;
        logic [BYTE_W-1:0] bat;
        logic [BYTE_W-1:0] soc;
    } hdr_t;

endpackage

FILE: rtl/core/probe_advert_payload_parser_core.sv
// Probe advertisement payload parser, top level.
// Depends on papp_pkg and papp_pair_ram.
//
//  channel  | signals                      | contents
//  ---------+------------------------------+---------------------------------------
//  s_*      | s_tvalid s_tready s_tdata    | payload byte; s_tlast marks final byte
//  m_*      | m_tvalid m_tready m_tdata    | one result per beat; m_tuser = status,
//           | m_tuser m_tlast              | m_tlast marks final result of a payload
//  cfg_*    | cfg_we cfg_idx cfg_data      | limit register writes
//
// One byte is taken per cycle while s_tready is high. A final byte launches 1 to 6 results,
// issued one per cycle, unless the read stage stalls, as reads of the two-bank pair RAM;
// each passes the job registers, the read stage and the output register. A final byte
// waits (s_tready low) while the previous payload is still issuing reads; other bytes do not.
// Reset clears counters and restores limits to -400 and 6000; the RAM is not cleared.
module probe_advert_payload_parser_core #(
    parameter int MAX_PAYLOAD = papp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [papp_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] payload_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] pkt_kind, [7:4] major, [11:8] minor, [15:12] patch,
    // [16] batt_flag, [24:17] batt_level, [32:25] soc_temp, [35:33] reading_slot,
    // [51:36] reading_tenths, [52] reading_valid, [55:53] zero
    output logic [papp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,   // [0] status
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic                                cfg_idx,
    input  logic [papp_pkg::TENTHS_W-1:0]       cfg_data
);

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int BW = papp_pkg::BYTE_W;
    localparam int CW = papp_pkg::CNT_W;
    localparam int LW = papp_pkg::LEN_W;
    localparam int TW = papp_pkg::TENTHS_W;
    localparam int SW = papp_pkg::SLOT_W;

    // limits
    logic signed [TW-1:0] min_tenths_reg;
    logic signed [TW-1:0] max_tenths_reg;

    // input side
    logic [CW-1:0] byte_count_reg;
    logic          wr_bank_reg;
    logic [BW-1:0] b0_reg, b1_reg, b2_reg, b3_reg, b8_reg, b9_reg;
    logic [BW-1:0] e0, e1, e2, e3, e8, e9;
    logic          in_acc;
    logic          in_done;
    logic [LW-1:0] len;

    // payload decode
    logic          len_ok, type_ok, is_temp, is_v3, reject;
    logic [2:0]    ntips;
    papp_pkg::hdr_t hdr_new;
    logic [1:0]    lay_new;
    logic [SW-1:0] lastk_new;

    // job descriptor
    logic           job_busy_reg;
    logic           job_bank_reg;
    logic [LW-1:0]  job_len_reg;
    logic           job_temp_reg;
    logic [1:0]     job_lay_reg;
    logic [SW-1:0]  job_lastk_reg;
    logic [SW-1:0]  job_k_reg;
    papp_pkg::hdr_t job_hdr_reg;

    // issue
    logic          issue;
    logic          issue_last;
    logic [3:0]    off;
    logic [AW-1:0] off_ext;
    logic          present;

    // read stage
    logic           s1_valid_reg;
    logic [SW-1:0]  s1_slot_reg;
    logic           s1_present_reg;
    logic           s1_last_reg;
    papp_pkg::hdr_t s1_hdr_reg;
    logic [TW-1:0]  rd_data;
    logic signed [TW-1:0] rd_val;
    logic           adv;

    // output register
    logic           out_valid_reg;
    logic [SW-1:0]  out_slot_reg;
    logic [TW-1:0]  out_tenths_reg;
    logic           out_rvalid_reg;
    logic           out_last_reg;
    papp_pkg::hdr_t out_hdr_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tenths_reg <= papp_pkg::MIN_TENTHS_RST;
            max_tenths_reg <= papp_pkg::MAX_TENTHS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                papp_pkg::REG_MIN_TENTHS: min_tenths_reg <= $signed(cfg_data);
                papp_pkg::REG_MAX_TENTHS: max_tenths_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- input
    assign s_tready = !s_tlast || !job_busy_reg || issue_last;
    assign in_acc   = s_tvalid && s_tready;
    assign in_done  = in_acc && s_tlast;
    assign len      = {1'b0, byte_count_reg} + LW'(1);

    assign e0 = (byte_count_reg == CW'(0)) ? s_tdata : b0_reg;
    assign e1 = (byte_count_reg == CW'(1)) ? s_tdata : b1_reg;
    assign e2 = (byte_count_reg == CW'(2)) ? s_tdata : b2_reg;
    assign e3 = (byte_count_reg == CW'(3)) ? s_tdata : b3_reg;
    assign e8 = (byte_count_reg == CW'(8)) ? s_tdata : b8_reg;
    assign e9 = (byte_count_reg == CW'(9)) ? s_tdata : b9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            wr_bank_reg    <= 1'b0;
        end
        else if (in_acc)
        begin
            if (s_tlast)
            begin
                byte_count_reg <= '0;
                wr_bank_reg    <= !wr_bank_reg;
            end
            else if (byte_count_reg != papp_pkg::CNT_SAT)
            begin
                byte_count_reg <= byte_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            b0_reg <= e0;
            b1_reg <= e1;
            b2_reg <= e2;
            b3_reg <= e3;
            b8_reg <= e8;
            b9_reg <= e9;
        end
    end

    // ---------------------------------------------------------------- decode
    assign len_ok  = (len >= papp_pkg::MIN_LEN) && (len <= LW'(MAX_PAYLOAD));
    assign type_ok = (e0[3:0] == papp_pkg::PT_NAME) || (e0[3:0] == papp_pkg::PT_TEMP)
                  || (e0[3:0] == papp_pkg::PT_STATUS);
    assign is_temp = (e0[3:0] == papp_pkg::PT_TEMP);
    assign is_v3   = (e1[7:4] >= papp_pkg::VER_MAJ_V3);
    assign reject  = !len_ok || !type_ok
                  || (is_temp && !is_v3 && (len < papp_pkg::MIN_TEMP_LEN));

    assign ntips = {2'b0, len >= LW'(8)} + {2'b0, len >= LW'(10)}
                 + {2'b0, len >= LW'(12)} + {2'b0, len >= LW'(14)};

    always_comb
    begin
        hdr_new   = '0;
        lay_new   = papp_pkg::LAY_V3;
        lastk_new = '0;
        if (reject)
        begin
            hdr_new.status = 1'b1;
        end
        else
        begin
            hdr_new.ptype = e0[3:0];
            hdr_new.pat   = e0[7:4];
            hdr_new.maj   = e1[7:4];
            hdr_new.mnr   = e1[3:0];
            if (is_temp)
            begin
                if (is_v3)
                begin
                    lay_new   = papp_pkg::LAY_V3;
                    lastk_new = SW'(1) + ntips;
                end
                else if (e1[7:4] == papp_pkg::VER_MAJ_V2)
                begin
                    lay_new     = papp_pkg::LAY_V2;
                    lastk_new   = SW'(4);
                    hdr_new.hb  = 1'b1;
                    hdr_new.bat = e2;
                    hdr_new.soc = e3;
                end
                else
                begin
                    lay_new     = papp_pkg::LAY_LEGACY;
                    lastk_new   = SW'(1);
                    hdr_new.hb  = 1'b1;
                    hdr_new.bat = e8;
                    hdr_new.soc = e9;
                end
            end
            else if ((e0[3:0] == papp_pkg::PT_STATUS) && is_v3
                     && (len >= papp_pkg::MIN_STATUS_LEN))
            begin
                hdr_new.hb  = 1'b1;
                hdr_new.bat = e8;
                hdr_new.soc = e9;
            end
        end
    end

    // ---------------------------------------------------------------- job
    assign issue      = job_busy_reg && (!s1_valid_reg || adv);
    assign issue_last = issue && (job_k_reg == job_lastk_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_busy_reg <= 1'b0;
            job_k_reg    <= '0;
        end
        else if (in_done)
        begin
            job_busy_reg <= 1'b1;
            job_k_reg    <= '0;
        end
        else if (issue)
        begin
            job_busy_reg <= !issue_last;
            job_k_reg    <= job_k_reg + SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_done)
        begin
            job_bank_reg  <= wr_bank_reg;
            job_len_reg   <= len;
            job_temp_reg  <= is_temp && !reject;
            job_lay_reg   <= lay_new;
            job_lastk_reg <= reject ? SW'(0) : lastk_new;
            job_hdr_reg   <= hdr_new;
        end
    end

    always_comb
    begin
        case (job_lay_reg)
            papp_pkg::LAY_V3: off = papp_pkg::OFF_V3_BASE + {job_k_reg, 1'b0};
            papp_pkg::LAY_V2: off = papp_pkg::OFF_V2_BASE + {job_k_reg, 1'b0};
            default:
                off = (job_k_reg == SW'(0)) ? papp_pkg::OFF_LEG_AMB : papp_pkg::OFF_LEG_FOOD;
        endcase
    end

    assign off_ext = AW'(off);
    assign present = job_temp_reg && (({2'b0, off} + LW'(2)) <= job_len_reg);

    papp_pair_ram #(
        .AW (AW)
    ) u_ram (
        .clk     (clk),
        .we      (in_acc && (byte_count_reg < CW'(MAX_PAYLOAD))),
        .wr_addr ({wr_bank_reg, byte_count_reg[AW-1:0]}),
        .wr_data (s_tdata),
        .re      (issue),
        .rd_addr ({job_bank_reg, off_ext[AW-1:1]}),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------- read stage
    assign adv    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign rd_val = $signed(rd_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_slot_reg    <= job_temp_reg ? job_k_reg : SW'(0);
            s1_present_reg <= present;
            s1_last_reg    <= issue_last;
            s1_hdr_reg     <= job_hdr_reg;
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_slot_reg   <= s1_slot_reg;
            out_tenths_reg <= s1_present_reg ? rd_data : '0;
            out_rvalid_reg <= s1_present_reg && (rd_val >= min_tenths_reg)
                              && (rd_val <= max_tenths_reg);
            out_last_reg   <= s1_last_reg;
            out_hdr_reg    <= s1_hdr_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hdr_reg.status;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{papp_pkg::OUT_PAD_W{1'b0}}, out_rvalid_reg, out_tenths_reg,
                       out_slot_reg, out_hdr_reg.soc, out_hdr_reg.bat, out_hdr_reg.hb,
                       out_hdr_reg.pat, out_hdr_reg.mnr, out_hdr_reg.maj,
                       out_hdr_reg.ptype};

endmodule

FILE: rtl/core/papp_pair_ram.sv
// Two-bank payload buffer: byte writes, 16-bit little-endian pair reads.
// Even and odd bytes live in separate arrays; read data registered. Uses papp_pkg.
module papp_pair_ram #(
    parameter int AW = 5
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [AW:0]                     wr_addr,
    input  logic [papp_pkg::BYTE_W-1:0]     wr_data,
    input  logic                            re,
    input  logic [AW-1:0]                   rd_addr,
    output logic [2*papp_pkg::BYTE_W-1:0]   rd_data
);

    localparam int WORDS = 1 << AW;

    logic [papp_pkg::BYTE_W-1:0] even_mem [0:WORDS-1];
    logic [papp_pkg::BYTE_W-1:0] odd_mem  [0:WORDS-1];
    logic [AW-1:0]               wr_word;

    assign wr_word = {wr_addr[AW], wr_addr[AW-1:1]};

    always_ff @(posedge clk)
    begin
        if (we && !wr_addr[0])
        begin
            even_mem[wr_word] <= wr_data;
        end
        if (we && wr_addr[0])
        begin
            odd_mem[wr_word] <= wr_data;
        end
        if (re)
        begin
            rd_data <= {odd_mem[rd_addr], even_mem[rd_addr]};
        end
    end

endmodule
